// File: rtl/core/apm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Audio peak LED meter package
// Shared widths, register codes, reset values and beat types.
// ----------------------------------------------------------------------------
package apm_pkg;

  // Register width of the configuration port and of the clip timer
  localparam int unsigned RegW = 24;

  // Defaults handed to the top-level parameters
  localparam int unsigned SampleBitsDef     = 24;
  localparam int unsigned MaxBlockFramesDef = 8192;

  // Register reset values
  localparam logic [RegW-1:0] GreenThreshRst = 24'd132954;
  localparam logic [RegW-1:0] RedThreshRst   = 24'd2107082;
  localparam logic [RegW-1:0] HoldFramesRst  = 24'd24000;

  // Register index codes
  typedef enum logic [1:0] {
    REG_GREEN_THRESH = 2'd0,
    REG_RED_THRESH   = 2'd1,
    REG_HOLD_FRAMES  = 2'd2
  } apm_reg_e;

  // Configuration register set
  typedef struct packed {
    logic [RegW-1:0] green_threshold;
    logic [RegW-1:0] red_threshold;
    logic [RegW-1:0] hold_frames;
  } apm_cfg_t;

  // One result beat
  typedef struct packed {
    logic            green_on;
    logic            red_on;
    logic [RegW-1:0] block_peak;
  } apm_result_t;

endpackage
`default_nettype wire

// File: rtl/core/apm_meter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Peak meter datapath
// Tracks block peak, frame count and the time-since-clip timer, and forms
// the LED result for a block-end sample.
// ----------------------------------------------------------------------------
module apm_meter #(
  parameter int unsigned SAMPLE_BITS      = apm_pkg::SampleBitsDef,
  parameter int unsigned MAX_BLOCK_FRAMES = apm_pkg::MaxBlockFramesDef
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           step_i,
  input  wire logic [SAMPLE_BITS-1:0]   sample_i,
  input  wire                           frame_end_i,
  input  wire                           block_end_i,
  input  wire apm_pkg::apm_cfg_t        cfg_i,
  output apm_pkg::apm_result_t          result_o
);

  localparam int unsigned RegW    = apm_pkg::RegW;
  localparam int unsigned CmpW    = (SAMPLE_BITS > RegW) ? SAMPLE_BITS : RegW;
  localparam int unsigned FrameW  = $clog2(MAX_BLOCK_FRAMES + 1);
  localparam logic [FrameW-1:0] FrameMax = FrameW'(MAX_BLOCK_FRAMES);
  localparam logic [RegW-1:0]   TimerMax = {RegW{1'b1}};

  logic [SAMPLE_BITS-1:0] peak_q, peak_d;
  logic [FrameW-1:0]      frames_q, frames_d;
  logic [RegW-1:0]        timer_q, timer_d;

  logic [SAMPLE_BITS-1:0] mag;
  logic [SAMPLE_BITS-1:0] peak_new;
  logic [FrameW-1:0]      frames_new;
  logic [CmpW-1:0]        peak_cmp;
  logic                   clip;
  logic [RegW-1:0]        timer_cur;
  logic [RegW:0]          timer_sum;

  // Magnitude: negating the most negative code yields its exact unsigned value
  assign mag = sample_i[SAMPLE_BITS-1] ? (~sample_i + 1'b1) : sample_i;

  // Running peak and saturating frame count including this sample
  assign peak_new   = (mag > peak_q) ? mag : peak_q;
  assign frames_new = (frame_end_i && (frames_q < FrameMax)) ? frames_q + 1'b1 : frames_q;

  // Block-end decisions
  assign peak_cmp  = CmpW'(peak_new);
  assign clip      = peak_cmp > CmpW'(cfg_i.red_threshold);
  assign timer_cur = clip ? '0 : timer_q;
  assign timer_sum = {1'b0, timer_cur} + (RegW + 1)'(frames_new);

  always_comb begin
    result_o.green_on   = peak_cmp > CmpW'(cfg_i.green_threshold);
    result_o.red_on     = timer_cur < cfg_i.hold_frames;
    result_o.block_peak = peak_cmp[RegW-1:0];
  end

  // Next state: clear accumulators at block end, advance timer saturating
  always_comb begin
    peak_d   = peak_q;
    frames_d = frames_q;
    timer_d  = timer_q;
    if (step_i) begin
      if (block_end_i) begin
        peak_d   = '0;
        frames_d = '0;
        timer_d  = timer_sum[RegW] ? TimerMax : timer_sum[RegW-1:0];
      end else begin
        peak_d   = peak_new;
        frames_d = frames_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q   <= '0;
      frames_q <= '0;
      timer_q  <= '0;
    end else begin
      peak_q   <= peak_d;
      frames_q <= frames_d;
      timer_q  <= timer_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/audio_peak_led_meter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: after its beat is taken, a block-end sample goes through the input register and its result
// through the output register, held longer while the result side stalls.
// Throughput: one sample per cycle while the skid slot is empty; the input register and the
// output register with its skid slot let samples keep flowing while one result waits downstream.
// Reset: thresholds and hold return to defaults, peak, frame count and clip timer
// clear, so red is lit on the first blocks after reset.
// ----------------------------------------------------------------------------
// Audio peak LED meter top level
// Input register, meter datapath, output register with skid slot, config.
// ----------------------------------------------------------------------------
module audio_peak_led_meter_top #(
  parameter int unsigned SAMPLE_BITS      = apm_pkg::SampleBitsDef,
  parameter int unsigned MAX_BLOCK_FRAMES = apm_pkg::MaxBlockFramesDef
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // Configuration write port
  input  wire                              cfg_we_i,
  input  wire logic [1:0]                  cfg_idx_i,
  input  wire logic [apm_pkg::RegW-1:0]    cfg_wdata_i,
  // Sample channel
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0]      sample_i,
  input  wire                              frame_end_i,
  input  wire                              block_end_i,
  // Result channel
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic                             green_on_o,
  output logic                             red_on_o,
  output logic [apm_pkg::RegW-1:0]         block_peak_o
);

  apm_pkg::apm_cfg_t    cfg_q;
  apm_pkg::apm_result_t result;
  apm_pkg::apm_result_t out_q, skid_q;
  logic                 out_valid_q, skid_valid_q;

  logic                   in_valid_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   frame_end_q, block_end_q;

  logic in_accept;
  logic step;
  logic emit;
  logic out_free;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.green_threshold <= apm_pkg::GreenThreshRst;
      cfg_q.red_threshold   <= apm_pkg::RedThreshRst;
      cfg_q.hold_frames     <= apm_pkg::HoldFramesRst;
    end else if (cfg_we_i) begin
      unique case (apm_pkg::apm_reg_e'(cfg_idx_i))
        apm_pkg::REG_GREEN_THRESH: cfg_q.green_threshold <= cfg_wdata_i;
        apm_pkg::REG_RED_THRESH:   cfg_q.red_threshold   <= cfg_wdata_i;
        apm_pkg::REG_HOLD_FRAMES:  cfg_q.hold_frames     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Advance the held sample unless the skid slot is occupied
  assign step       = in_valid_q && !skid_valid_q;
  assign in_stall_o = in_valid_q && skid_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign emit       = step && block_end_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q    <= sample_i;
      frame_end_q <= frame_end_i;
      block_end_q <= block_end_i;
    end
  end

  apm_meter #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .MAX_BLOCK_FRAMES (MAX_BLOCK_FRAMES)
  ) u_meter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .sample_i    (sample_q),
    .frame_end_i (frame_end_q),
    .block_end_i (block_end_q),
    .cfg_i       (cfg_q),
    .result_o    (result)
  );

  // Output register with skid slot: refill from skid first, park a new beat when blocked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q  <= skid_valid_q || emit;
        skid_valid_q <= 1'b0;
      end else if (emit) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (emit) begin
        out_q <= result;
      end
    end else if (emit) begin
      skid_q <= result;
    end
  end

  // Drive result ports
  assign out_valid_o  = out_valid_q;
  assign green_on_o   = out_q.green_on;
  assign red_on_o     = out_q.red_on;
  assign block_peak_o = out_q.block_peak;

endmodule
`default_nettype wire
